/* rtl/sha256_pkg.sv */
package sha256_pkg;

  localparam int unsigned QueueDepth = 4;

  // Item handed from the front end to the compression engine.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } sha_item_t;

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [255:0] init_hash();
    return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  endfunction

  localparam logic [7:0] PadByte = 8'h80;

endpackage

/* rtl/sha256_queue.sv */
module sha256_queue #(
  parameter int unsigned DEPTH = sha256_pkg::QueueDepth
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  sha256_pkg::sha_item_t wr_item,
  output logic                  rd_valid,
  input  logic                  rd_ready,
  output sha256_pkg::sha_item_t rd_item
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha256_pkg::sha_item_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_wr, do_rd;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH)) else $error("queue count beyond depth");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count slip");
  a_empty_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !do_rd) else $error("read from empty queue");
endmodule

/* rtl/sha256_engine.sv */
module sha256_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  sha256_pkg::sha_item_t item,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [63:0]           res_word,
  output logic [1:0]            res_index,
  output logic                  res_last
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ROUND = 6'b000010,
    S_FOLD  = 6'b000100,
    S_PAD   = 6'b001000,
    S_LEN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [31:0]   w_r [16];     // schedule window, w_r[0] is word t
  logic [511:0]  blk_r;        // bytes shift in at the low end
  logic [255:0]  h_r;
  logic [31:0]   a_r, b_r, c_r, d_r, e_r, f_r, g_r, hh_r;
  logic [5:0]    rnd_r;
  logic [63:0]   cnt_r, len_r;
  logic [5:0]    fill_r;       // bytes placed in the current block
  logic          fin_r;        // compressing the final padded block
  logic          ovf_r;        // length needs its own block
  logic [1:0]    oidx_r;

  logic [31:0] s0, s1, bs0, bs1, ch, mj, t1, t2, wn;
  logic [5:0]  pos;

  always_comb begin
    s0  = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    s1  = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
        ^ (w_r[14] >> 10);
    wn  = w_r[0] + s0 + w_r[9] + s1;
    bs1 = {e_r[5:0], e_r[31:6]} ^ {e_r[10:0], e_r[31:11]} ^ {e_r[24:0], e_r[31:25]};
    ch  = (e_r & f_r) ^ (~e_r & g_r);
    t1  = hh_r + bs1 + ch + sha256_pkg::round_const(rnd_r) + w_r[0];
    bs0 = {a_r[1:0], a_r[31:2]} ^ {a_r[12:0], a_r[31:13]} ^ {a_r[21:0], a_r[31:22]};
    mj  = (a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r);
    t2  = bs0 + mj;
    pos = cnt_r[8:3];
  end

  assign item_ready = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_OUT);
  assign res_word   = h_r[255 - 64*oidx_r -: 64];
  assign res_index  = oidx_r;
  assign res_last   = (oidx_r == 2'd3);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (item_valid) begin
        if (item.byte_valid && pos == 6'd63) state_nxt = S_ROUND;
        else if (item.last) state_nxt = S_PAD;
      end
      S_ROUND: if (rnd_r == 6'd63) state_nxt = S_FOLD;
      S_FOLD:  state_nxt = fin_r ? S_OUT : (ovf_r ? S_LEN : (len_r[0] ? S_PAD : S_IDLE));
      S_PAD:   begin
        if (fill_r == 6'd0 || fill_r == 6'd63) state_nxt = S_ROUND;
        else if (fill_r == 6'd55 || fill_r == 6'd56) state_nxt = S_LEN;
      end
      S_LEN:   if (fill_r == 6'd63) state_nxt = S_ROUND;
      S_OUT:   if (res_ready && oidx_r == 2'd3) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // len_r[0] is reused before padding as a pending flag; real length captured at PAD.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      h_r     <= sha256_pkg::init_hash();
      cnt_r   <= '0;
      fill_r  <= '0;
      rnd_r   <= '0;
      fin_r   <= 1'b0;
      ovf_r   <= 1'b0;
      oidx_r  <= '0;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: if (item_valid) begin
          if (item.byte_valid) begin
            cnt_r <= cnt_r + 64'd8;
          end
          if (item.byte_valid && pos == 6'd63) begin
            blk_r <= {blk_r[503:0], item.data_byte};
            len_r <= {63'd0, item.last};
            for (int i = 0; i < 16; i++) begin
              w_r[i] <= (i == 15) ? {blk_r[23:0], item.data_byte}
                                  : blk_r[503 - 32*i -: 32];
            end
            {a_r, b_r, c_r, d_r, e_r, f_r, g_r, hh_r} <= h_r;
            rnd_r <= '0;
            fin_r <= 1'b0;
            ovf_r <= 1'b0;
          end else if (item.last) begin
            blk_r  <= item.byte_valid ? {blk_r[495:0], item.data_byte, sha256_pkg::PadByte}
                                      : {blk_r[503:0], sha256_pkg::PadByte};
            fill_r <= item.byte_valid ? pos + 6'd2 : pos + 6'd1;
            len_r  <= item.byte_valid ? cnt_r + 64'd8 : cnt_r;
            ovf_r  <= item.byte_valid ? (pos + 6'd1 > 6'd55) : (pos > 6'd55);
          end else if (item.byte_valid) begin
            blk_r  <= {blk_r[503:0], item.data_byte};
            fill_r <= pos + 6'd1;
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wn;
          hh_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
          d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
          rnd_r <= rnd_r + 6'd1;
        end
        S_FOLD: begin
          h_r <= {h_r[255:224] + a_r, h_r[223:192] + b_r, h_r[191:160] + c_r,
                  h_r[159:128] + d_r, h_r[127:96] + e_r, h_r[95:64] + f_r,
                  h_r[63:32] + g_r, h_r[31:0] + hh_r};
          if (!fin_r && ovf_r) begin
            ovf_r  <= 1'b0;
            fill_r <= '0;
          end else if (!fin_r && len_r[0]) begin
            // full block finished on the last byte: pad in a fresh block
            blk_r  <= {blk_r[503:0], sha256_pkg::PadByte};
            fill_r <= 6'd1;
            len_r  <= cnt_r;
            ovf_r  <= 1'b0;
          end
          oidx_r <= '0;
        end
        S_PAD: begin
          if (fill_r == 6'd0) begin
            // the pad byte filled the last slot; compress it, length follows
            for (int i = 0; i < 16; i++) begin
              w_r[i] <= blk_r[511 - 32*i -: 32];
            end
            {a_r, b_r, c_r, d_r, e_r, f_r, g_r, hh_r} <= h_r;
            rnd_r <= '0;
            fin_r <= 1'b0;
            ovf_r <= 1'b1;
          end else if (fill_r != 6'd56) begin
            blk_r  <= {blk_r[503:0], 8'h00};
            fill_r <= fill_r + 6'd1;
            if (fill_r == 6'd63) begin
              // overflow block complete; compress it, length follows
              for (int i = 0; i < 16; i++) begin
                w_r[i] <= (i == 15) ? {blk_r[23:0], 8'h00} : blk_r[503 - 32*i -: 32];
              end
              {a_r, b_r, c_r, d_r, e_r, f_r, g_r, hh_r} <= h_r;
              rnd_r <= '0;
              fin_r <= 1'b0;
              ovf_r <= 1'b1;
            end
          end
        end
        S_LEN: begin
          blk_r  <= {blk_r[503:0], (fill_r < 6'd56) ? 8'h00 : len_r[63 - 8*(fill_r - 6'd56) -: 8]};
          fill_r <= fill_r + 6'd1;
          if (fill_r == 6'd63) begin
            for (int i = 0; i < 16; i++) begin
              w_r[i] <= (i == 15) ? {blk_r[23:0], len_r[7:0]} : blk_r[503 - 32*i -: 32];
            end
            {a_r, b_r, c_r, d_r, e_r, f_r, g_r, hh_r} <= h_r;
            rnd_r <= '0;
            fin_r <= 1'b1;
          end
        end
        S_OUT: if (res_ready) begin
          oidx_r <= oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            h_r   <= sha256_pkg::init_hash();
            cnt_r <= '0;
            fin_r <= 1'b0;
            len_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_out_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> fin_r) else $error("digest shown before final block");
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && rnd_r == 6'd63) |=> state_r == S_FOLD)
    else $error("round count slip");
  a_reset_after: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && res_ready && oidx_r == 2'd3) |=> cnt_r == '0)
    else $error("bit count not cleared after digest");
endmodule

/* rtl/sha256_message_hasher_core.sv */
// SHA-256 byte-stream hasher. Each input transaction carries one byte (tdata), a
// byte-valid flag (tuser) and a last flag (tlast); an item with byte-valid low and
// last high closes the message without adding a byte, so an empty message is legal.
// A small queue decouples the input port from the compression engine. A byte that
// does not complete a 64-byte block is taken while the engine is idle; the byte that
// completes a block starts the rounds and then the fold in the single shared round
// unit, and no further item is taken until they are done. After the last transaction
// the pad and length block is built and then compressed. When the length does not
// fit, the pad block gets a compression of its own before the length block is built
// and compressed. The digest then leaves as four 64-bit big-endian output
// transactions, the first two chaining words first. After the fourth the hash state
// returns to its initial value for the next message.
module sha256_message_hasher_core #(
  parameter int unsigned QUEUE_DEPTH = sha256_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // byte_valid
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // digest_word
  output logic [1:0]  out_tuser,  // word_index
  output logic        out_tlast   // last_word
);
  sha256_pkg::sha_item_t in_item, q_item;
  logic q_valid, q_ready;

  assign in_item = '{data_byte: in_tdata, byte_valid: in_tuser, last: in_tlast};

  sha256_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n,
    .wr_valid(in_tvalid), .wr_ready(in_tready), .wr_item(in_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  sha256_engine u_engine (
    .clk, .rst_n,
    .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .res_valid(out_tvalid), .res_ready(out_tready),
    .res_word(out_tdata), .res_index(out_tuser), .res_last(out_tlast)
  );
endmodule

/* dv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: a SHA-256 predictor over the byte stream and a queue of expected
  // digest quarters. One accepted input transaction is noted by note_byte; each
  // accepted output transaction is compared by check_word.
  class sha_scoreboard;
    logic [31:0] chain[8];
    logic [7:0]  blk[64];
    logic [63:0] nbits;
    logic [66:0] digest_q[$];   // {digest_word, word_index, last_word}
    int          errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      logic [255:0] iv;
      iv = sha256_pkg::init_hash();
      for (int i = 0; i < 8; i++) chain[i] = iv[255-32*i -: 32];
      nbits = '0;
    endfunction

    function automatic logic [31:0] rotr(logic [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w[64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, x;
      logic [31:0] kc[64];
      kc = '{32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
             32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
             32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
             32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
             32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
             32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
             32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
             32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
             32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
             32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
             32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      for (int t = 0; t < 16; t++) w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      for (int t = 16; t < 64; t++) begin
        x = w[t-15];
        t1 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
        x = w[t-2];
        t2 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
        w[t] = w[t-16] + t1 + w[t-7] + t2;
      end
      {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                  chain[4], chain[5], chain[6], chain[7]};
      for (int t = 0; t < 64; t++) begin
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + kc[t] + w[t];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    function void note_byte(logic [7:0] data, logic valid, logic fin);
      int pos;
      logic [63:0] len;
      if (valid) begin
        pos = int'(nbits[8:3]);
        blk[pos] = data;
        nbits += 64'd8;
        if (pos == 63) compress();
      end
      if (!fin) return;
      len = nbits;
      pos = int'(nbits[8:3]);
      blk[pos] = sha256_pkg::PadByte;
      pos++;
      // When the length no longer fits, the pad block is flushed on its own.
      if (pos > 56) begin
        while (pos < 64) blk[pos++] = 8'h00;
        compress();
        pos = 0;
      end
      while (pos < 56) blk[pos++] = 8'h00;
      for (int k = 0; k < 8; k++) blk[56+k] = len[63-8*k -: 8];
      compress();
      for (int k = 0; k < 4; k++)
        digest_q.insert(digest_q.size(), {chain[2*k], chain[2*k+1], 2'(k), k == 3});
      restart();
    endfunction

    function void check_word(logic [63:0] word, logic [1:0] idx, logic lw);
      logic [66:0] exp_w;
      if (digest_q.size() == 0) begin
        report_error($sformatf("unexpected digest word %h idx %0d", word, idx));
        return;
      end
      exp_w = digest_q.pop_front();
      if (word !== exp_w[66:3] || idx !== exp_w[2:1] || lw !== exp_w[0])
        report_error($sformatf("digest word %h/%0d/%0b, expected %h/%0d/%0b",
                               word, idx, lw, exp_w[66:3], exp_w[2:1], exp_w[0]));
    endfunction

    function void report_error(string msg);
      errors++;
      if (errors <= 20) $display("mismatch: %s", msg);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // data_byte
  logic        in_tuser = 1'b0; // byte_valid
  logic        in_tlast = 1'b0; // last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // digest_word
  logic [1:0]  out_tuser;       // word_index
  logic        out_tlast;       // last_word

  sha_scoreboard sb = new();
  int send_idle_pct = 0;   // chance, in percent, that the sender skips a cycle
  int recv_stall_pct = 0;  // chance, in percent, that the receiver stalls
  int cycles = 0;
  bit finishing = 0;

  always #5 clk = ~clk;

  sha256_message_hasher_core u_dut (.*);

  // The receiver decides its ready for the next cycle at every rising edge, and
  // an output transaction is checked exactly when valid and ready were both high.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser, out_tlast);
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    if (cycles > 2000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Drives one item and holds it until the transaction completes. The valid is
  // only lowered for an idle gap, never lowered and raised in one time step.
  task automatic send_item(logic [7:0] data, logic valid, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= valid;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(data, valid, fin);
  endtask

  // One message of n random bytes. Sometimes the final byte carries last,
  // otherwise an empty tail closes it; idle items are sprinkled in. With
  // byte_close set, the final byte always carries last.
  task automatic send_message(int n, bit byte_close = 1'b0);
    bit tail_close;
    tail_close = (n == 0) || (!byte_close && $urandom_range(1));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, !tail_close && i == n - 1);
    end
    if (tail_close) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int sent;
    int phase;
    int dir_len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: idle item, empty message and short messages.
    send_item(8'h00, 1'b0, 1'b0);           // idle item
    send_item(8'h00, 1'b0, 1'b1);           // empty string
    send_item(8'hff, 1'b1, 1'b1);           // one byte with last
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h80, 1'b0, 1'b1);           // closed by an empty tail

    // Random part in four idling phases, each opening with a block-boundary case:
    // length just fits, pad overflow, pad byte ending the block, and a full block
    // on the final byte.
    sent = 0;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  dir_len = 55; end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  dir_len = 56; end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; dir_len = 63; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; dir_len = 64; end
      endcase
      send_message(dir_len, phase == 3);
      sent += dir_len + 1;
      while (sent < 70 * (phase + 1)) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(12);
        send_message(n);
        sent += n + 1;
      end
    end
    in_tvalid <= 1'b0;

    while (sb.digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* sha256_message_hasher_core.f */
rtl/sha256_pkg.sv
rtl/sha256_queue.sv
rtl/sha256_engine.sv
rtl/sha256_message_hasher_core.sv
dv/tb.sv
